// File: rtl/core/rdc_pkg.sv
// Shared constants, state encoding, glyph lookup and radix clamp for the radix digit converter.
// No dependencies; used by radix_digit_converter and rdc_checker.
package rdc_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int MAX_DIGITS_DEF  = 31;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_A      = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_F      = 7'd70;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {3'b000, d};
        if (d < 4'd10)
            glyph = CHAR_ZERO + dx;
        else
            glyph = CHAR_A - 7'd10 + dx;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN)
            clamp_radix = RADIX_MIN;
        else if (r > RADIX_MAX)
            clamp_radix = RADIX_MAX;
        else
            clamp_radix = r;
    endfunction

endpackage

// File: rtl/core/radix_digit_converter.sv
// Radix digit converter top level: bit-serial division by the base, digit stack, ASCII output.
// Depends on rdc_pkg.
//
//  channel   signals                               transfer when
//  -------   -----------------------------------   -----------------------
//  command   start, busy, value                    start & !busy
//  config    cfg_valid, cfg_ready, cfg_data        cfg_valid & cfg_ready
//  result    strobe, digit_char, last_digit        strobe (one cycle each)
//
//  Each digit comes from a full pass of the shared restoring divide step, one
//  quotient bit per cycle; once division ends, the digits are output one
//  digit a cycle, most significant first.
//  busy stays high from the accepting edge until the final digit is driven.
//  Reset clears control state and sets the base to ten; the receiver cannot stall.
module radix_digit_converter #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [VALUE_WIDTH-1:0]        value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rdc_pkg::RADIX_W-1:0]   cfg_data,
    output logic                          strobe,
    output logic [rdc_pkg::CHAR_W-1:0]    digit_char,
    output logic                          last_digit
);

    localparam int BIT_W   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int STACK_W = MAX_DIGITS * rdc_pkg::DIGIT_W;

    rdc_pkg::state_t                  state_reg, state_next;
    logic [rdc_pkg::RADIX_W-1:0]      radix_reg;
    logic [rdc_pkg::RADIX_W-1:0]      base_reg, base_next;
    logic [VALUE_WIDTH-1:0]           quot_reg, quot_next;
    logic [rdc_pkg::DIGIT_W-1:0]      rem_reg, rem_next;
    logic                             nz_reg, nz_next;
    logic [BIT_W-1:0]                 bit_reg, bit_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [STACK_W-1:0]               stack_reg, stack_next;
    logic                             strobe_reg, strobe_next;
    logic [rdc_pkg::CHAR_W-1:0]       char_reg, char_next;
    logic                             last_reg, last_next;

    logic [rdc_pkg::RADIX_W-1:0]      trial;
    logic                             qbit;
    logic [rdc_pkg::RADIX_W-1:0]      trial_sub;
    logic [rdc_pkg::DIGIT_W-1:0]      rem_step;
    logic [VALUE_WIDTH:0]             quot_shift;
    logic [STACK_W+rdc_pkg::DIGIT_W-1:0] stack_push;
    logic [CNT_W-1:0]                 count_inc;
    logic                             pass_done;

    assign cfg_ready  = 1'b1;
    assign busy       = (state_reg != rdc_pkg::S_IDLE);
    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

    // restoring divide step: one quotient bit per cycle
    assign trial      = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign qbit       = (trial >= base_reg);
    assign trial_sub  = trial - base_reg;
    assign rem_step   = qbit ? trial_sub[rdc_pkg::DIGIT_W-1:0] : trial[rdc_pkg::DIGIT_W-1:0];
    assign quot_shift = {quot_reg, qbit};
    assign stack_push = {stack_reg, rem_step};
    assign count_inc  = count_reg + 1'b1;
    assign pass_done  = (bit_reg == BIT_W'(VALUE_WIDTH - 1));

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        nz_next     = nz_reg;
        bit_next    = bit_reg;
        count_next  = count_reg;
        stack_next  = stack_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            rdc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    base_next  = radix_reg;
                    quot_next  = value;
                    rem_next   = '0;
                    nz_next    = 1'b0;
                    bit_next   = '0;
                    count_next = '0;
                    state_next = rdc_pkg::S_DIV;
                end
            end
            rdc_pkg::S_DIV:
            begin
                quot_next = quot_shift[VALUE_WIDTH-1:0];
                rem_next  = rem_step;
                nz_next   = nz_reg | qbit;
                bit_next  = bit_reg + 1'b1;
                if (pass_done)
                begin
                    // push the remainder as the next digit, start a fresh pass
                    stack_next = stack_push[STACK_W-1:0];
                    count_next = count_inc;
                    rem_next   = '0;
                    nz_next    = 1'b0;
                    bit_next   = '0;
                    if (!(nz_reg | qbit) || (count_inc >= CNT_W'(MAX_DIGITS)))
                        state_next = rdc_pkg::S_EMIT;
                end
            end
            rdc_pkg::S_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = rdc_pkg::glyph(stack_reg[rdc_pkg::DIGIT_W-1:0]);
                last_next   = (count_reg == CNT_W'(1));
                stack_next  = stack_reg >> rdc_pkg::DIGIT_W;
                count_next  = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                    state_next = rdc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rdc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rdc_pkg::S_IDLE;
            radix_reg  <= rdc_pkg::RADIX_RESET;
            count_reg  <= '0;
            bit_reg    <= '0;
            nz_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            bit_reg    <= bit_next;
            nz_reg     <= nz_next;
            strobe_reg <= strobe_next;
            if (cfg_valid && cfg_ready)
                radix_reg <= rdc_pkg::clamp_radix(cfg_data);
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        stack_reg <= stack_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

endmodule

// File: rtl/core/rdc_checker.sv
// Port-level checker for radix_digit_converter, with its bind statement.
// Depends on rdc_pkg and the radix_digit_converter port list.
module rdc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        strobe,
    input logic [rdc_pkg::CHAR_W-1:0]  digit_char,
    input logic                        last_digit
);

    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without a preceding busy cycle");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((digit_char >= rdc_pkg::CHAR_ZERO && digit_char <= rdc_pkg::CHAR_NINE) ||
                    (digit_char >= rdc_pkg::CHAR_A && digit_char <= rdc_pkg::CHAR_F)))
        else $error("digit character outside 0-9, A-F");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_digit) |=> strobe)
        else $error("digit run broken before last digit");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_digit) |-> (!busy ##1 !strobe))
        else $error("activity after last digit");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for radix_digit_converter: directed and random conversions over many bases,
// each digit checked against a local prediction. Depends on rdc_pkg and the RTL top.
module tb_top;

    localparam int VW            = rdc_pkg::VALUE_WIDTH_DEF;
    localparam int MAXD          = rdc_pkg::MAX_DIGITS_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 1100;
    localparam int LIMIT_CYCLES  = 1000000;

    typedef enum logic [1:0] {
        JOB_CONVERT,
        JOB_SET_RADIX,
        JOB_SETTLE
    } job_kind_t;

    typedef struct {
        job_kind_t                   kind;
        logic [VW-1:0]               number;
        logic [rdc_pkg::RADIX_W-1:0] radix;
        int                          gap;
    } job_t;

    typedef struct {
        logic [rdc_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } digit_t;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         start      = 1'b0;
    logic                         busy;
    logic [VW-1:0]                value      = '0;
    logic                         cfg_valid  = 1'b0;
    logic                         cfg_ready;
    logic [rdc_pkg::RADIX_W-1:0]  cfg_data   = '0;
    logic                         strobe;
    logic [rdc_pkg::CHAR_W-1:0]   digit_char;
    logic                         last_digit;

    job_t                         conversion_jobs[$];
    digit_t                       pending_digits[$];
    job_t                         cur_job;
    logic                         job_loaded   = 1'b0;
    int                           idle_left    = 0;
    int                           quiet_cycles = 0;
    logic [rdc_pkg::RADIX_W-1:0]  radix_model  = rdc_pkg::RADIX_RESET;
    logic [16:0]                  bases_used   = '0;
    int                           mismatches     = 0;
    int                           conversions    = 0;
    int                           digits_checked = 0;
    int                           radix_writes   = 0;
    int                           cycle_count    = 0;

    radix_digit_converter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Divide repeatedly, then queue the digits most significant first.
    function automatic void convert_to_digits(input logic [VW-1:0] number,
                                              input logic [rdc_pkg::RADIX_W-1:0] base);
        logic [rdc_pkg::DIGIT_W-1:0] low_first[$];
        logic [VW-1:0]               rest;
        logic [rdc_pkg::DIGIT_W-1:0] d;
        digit_t                      item;
        rest = number;
        do
        begin
            low_first.push_back(rdc_pkg::DIGIT_W'(rest % base));
            rest = rest / base;
        end
        while (rest != 0 && low_first.size() < MAXD);
        for (int k = low_first.size() - 1; k >= 0; k--)
        begin
            d       = low_first[k];
            item.ch = (d < 4'd10) ? rdc_pkg::CHAR_W'(rdc_pkg::CHAR_ZERO + d)
                                  : rdc_pkg::CHAR_W'(rdc_pkg::CHAR_A + d - 7'd10);
            item.last = (k == 0);
            pending_digits.push_back(item);
        end
    endfunction

    task automatic add_convert(input logic [VW-1:0] number, input int gap);
        job_t j;
        j.kind   = JOB_CONVERT;
        j.number = number;
        j.radix  = '0;
        j.gap    = gap;
        conversion_jobs.push_back(j);
    endtask

    task automatic add_job(input job_kind_t kind, input logic [rdc_pkg::RADIX_W-1:0] radix);
        job_t j;
        j.kind   = kind;
        j.number = '0;
        j.radix  = radix;
        j.gap    = 0;
        conversion_jobs.push_back(j);
    endtask

    // Driver: one transfer in flight at a time; radix writes only once the block is quiet.
    always @(posedge clk)
    begin : drive
        logic start_nxt;
        logic cfg_valid_nxt;
        start_nxt     = start;
        cfg_valid_nxt = cfg_valid;
        if (!rst_n)
        begin
            start_nxt     = 1'b0;
            cfg_valid_nxt = 1'b0;
            job_loaded    = 1'b0;
            idle_left     = 0;
            quiet_cycles  = 0;
        end
        else
        begin
            if (start && !busy)
                start_nxt = 1'b0;
            if (cfg_valid && cfg_ready)
                cfg_valid_nxt = 1'b0;
            if (!busy && !start && !cfg_valid && pending_digits.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!start_nxt && !cfg_valid_nxt)
            begin
                if (!job_loaded && conversion_jobs.size() != 0)
                begin
                    cur_job    = conversion_jobs.pop_front();
                    job_loaded = 1'b1;
                    idle_left  = cur_job.gap;
                end
                if (job_loaded)
                begin
                    if (idle_left != 0)
                    begin
                        if (!busy)
                            idle_left--;
                    end
                    else if (cur_job.kind == JOB_CONVERT)
                    begin
                        start_nxt  = 1'b1;
                        value     <= cur_job.number;
                        job_loaded = 1'b0;
                    end
                    else if (quiet_cycles >= SETTLE_CYCLES)
                    begin
                        if (cur_job.kind == JOB_SET_RADIX)
                        begin
                            cfg_valid_nxt = 1'b1;
                            cfg_data     <= cur_job.radix;
                        end
                        job_loaded = 1'b0;
                    end
                end
            end
        end
        start     <= start_nxt;
        cfg_valid <= cfg_valid_nxt;
    end

    // Monitor: check each digit, then predict for any transfer at this edge.
    always @(posedge clk)
    begin : watch
        digit_t due;
        if (rst_n)
        begin
            if (strobe !== 1'b0)
            begin
                if (strobe !== 1'b1)
                    report_mismatch("strobe is unknown");
                else if (pending_digits.size() == 0)
                    report_mismatch($sformatf("unexpected digit 0x%0h", digit_char));
                else
                begin
                    due = pending_digits.pop_front();
                    digits_checked++;
                    if (digit_char !== due.ch)
                        report_mismatch($sformatf("digit_char 0x%0h, want 0x%0h",
                                                  digit_char, due.ch));
                    if (last_digit !== due.last)
                        report_mismatch($sformatf("last_digit %b, want %b",
                                                  last_digit, due.last));
                end
            end
            if (start && !busy)
            begin
                convert_to_digits(value, radix_model);
                bases_used[radix_model] = 1'b1;
                conversions++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data < rdc_pkg::RADIX_MIN)
                    radix_model = rdc_pkg::RADIX_MIN;
                else if (cfg_data > rdc_pkg::RADIX_MAX)
                    radix_model = rdc_pkg::RADIX_MAX;
                else
                    radix_model = cfg_data;
                radix_writes++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [VW-1:0] all_ones;
        logic [VW-1:0] number;
        int            gap;
        all_ones = '1;

        // Directed: reset base first, then every clamp boundary.
        add_convert('0, 0);
        add_convert(VW'(9), 0);
        add_convert(VW'(10), 2);
        add_convert(VW'(1), 0);
        add_convert(all_ones, 0);
        add_job(JOB_SET_RADIX, 5'd2);
        add_convert('0, 0);
        add_convert(VW'(1), 0);
        add_convert(all_ones, 0);
        add_convert(VW'(32'h4000_0000), 3);
        add_job(JOB_SET_RADIX, 5'd16);
        add_convert(all_ones, 0);
        add_convert(VW'(15), 0);
        add_convert(VW'(32'h7EDC_BA98), 0);
        add_convert('0, 0);
        add_job(JOB_SET_RADIX, 5'd0);
        add_convert(VW'(5), 0);
        add_job(JOB_SET_RADIX, 5'd31);
        add_convert(VW'(255), 0);
        add_job(JOB_SET_RADIX, 5'd1);
        add_convert(VW'(3), 0);
        add_job(JOB_SET_RADIX, 5'd17);
        add_convert(VW'(32'h7FED_CBA9), 0);
        add_job(JOB_SET_RADIX, 5'd3);
        add_convert(all_ones, 0);
        add_convert(VW'(32'h2AAA_AAAA), 0);
        add_convert(VW'(32'h5555_5555), 0);

        // Random: six bases of 21 conversions; the last one runs without gaps.
        for (int phase = 0; phase < 6; phase++)
        begin
            if ($urandom_range(0, 3) == 0)
                add_job(JOB_SET_RADIX, rdc_pkg::RADIX_W'($urandom_range(0, 31)));
            else
                add_job(JOB_SET_RADIX, rdc_pkg::RADIX_W'($urandom_range(2, 16)));
            for (int n = 0; n < 21; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                    number = all_ones;
                else
                    number = VW'($urandom) >> $urandom_range(0, VW);
                gap = 0;
                if (phase < 5 && $urandom_range(0, 2) == 0)
                    gap = $urandom_range(1, 15);
                add_convert(number, gap);
                if (phase == 2 && n == 12)
                    add_job(JOB_SETTLE, '0);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (conversion_jobs.size() != 0 || job_loaded || start || cfg_valid)
            @(posedge clk);
        while (pending_digits.size() != 0 || busy)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d conversions, %0d digits checked, %0d radix writes",
                 conversions, digits_checked, radix_writes);
        $display("tb: base usage mask %b over bases 16..0, %0d mismatches",
                 bases_used, mismatches);
        if (mismatches == 0 && pending_digits.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
